FILE: rtl/core/ritoa_pkg.sv
// ----------------------------------------------------------------------------
// ritoa_pkg
// Shared types, constants and the digit-to-ASCII mapping of the radix
// integer to ASCII converter.
// ----------------------------------------------------------------------------
package ritoa_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_DIGITS_DEF = 32;

	// quotient bits resolved per divider cycle
	localparam int DIV_STEP_BITS = 8;

	localparam int RADIX_BITS  = 5;
	localparam int DIGIT_BITS  = 4;
	localparam int CHAR_BITS   = 7;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_BITS-1:0] BASE_MIN    = 5'd2;
	localparam logic [RADIX_BITS-1:0] BASE_MAX    = 5'd16;

	localparam logic [DIGIT_BITS-1:0] DEC_LIMIT = 4'd10;
	localparam logic [CHAR_BITS-1:0]  ASC_ZERO  = 7'd48;
	localparam logic [CHAR_BITS-1:0]  ASC_A     = 7'd65;

	// register index, taken from paddr[2]
	localparam logic REG_RADIX = 1'b0;

	typedef struct packed {
		logic load;   // latch value and base, clear remainder
		logic step;   // run one group of long-division steps
		logic store;  // write remainder to the digit memory, clear it
		logic rd;     // read one digit for output
	} ritoa_cmd_t;

	function automatic logic [CHAR_BITS-1:0] to_ascii(input logic [DIGIT_BITS-1:0] d);
		if (d < DEC_LIMIT) begin
			return ASC_ZERO + CHAR_BITS'(d);
		end
		return ASC_A + CHAR_BITS'(d - DEC_LIMIT);
	endfunction

endpackage

FILE: rtl/core/ritoa_dp.sv
// ----------------------------------------------------------------------------
// ritoa_dp
// Datapath: iterative divider by the base, digit memory and output register.
// ----------------------------------------------------------------------------
module ritoa_dp import ritoa_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  ritoa_cmd_t                    cmd,
	input  logic [$clog2(MAX_DIGITS)-1:0] mem_addr,
	input  logic [VALUE_BITS-1:0]         value,
	input  logic [RADIX_BITS-1:0]         radix,
	output logic                          q_zero,
	output logic [CHAR_BITS-1:0]          digit_char
);

	localparam int NSTEP = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
	localparam int QW    = NSTEP * DIV_STEP_BITS;

	logic [QW-1:0]            q_q;
	logic [DIGIT_BITS-1:0]    r_q;
	logic [RADIX_BITS-1:0]    base_q;
	logic [DIGIT_BITS-1:0]    rd_q;
	logic [DIGIT_BITS-1:0]    mem [MAX_DIGITS];

	logic [RADIX_BITS-1:0]    base_eff;
	logic [QW-1:0]            q_next;
	logic [DIGIT_BITS-1:0]    r_next;
	logic [DIV_STEP_BITS-1:0] qbits;

	always_comb begin
		if (radix < BASE_MIN) begin
			base_eff = BASE_MIN;
		end else if (radix > BASE_MAX) begin
			base_eff = BASE_MAX;
		end else begin
			base_eff = radix;
		end
	end

	// long division, one dividend bit per step, remainder stays below the base
	always_comb begin
		logic [DIGIT_BITS-1:0] r;
		logic [DIGIT_BITS:0]   t;
		r     = r_q;
		qbits = '0;
		for (int i = 0; i < DIV_STEP_BITS; i++) begin
			t = {r, q_q[QW-1-i]};
			if (t >= base_q) begin
				qbits[DIV_STEP_BITS-1-i] = 1'b1;
				r = DIGIT_BITS'(t - base_q);
			end else begin
				r = t[DIGIT_BITS-1:0];
			end
		end
		r_next = r;
		q_next = (q_q << DIV_STEP_BITS) | QW'(qbits);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q    <= QW'(value);
			r_q    <= '0;
			base_q <= base_eff;
		end else if (cmd.step) begin
			q_q <= q_next;
			r_q <= r_next;
		end else if (cmd.store) begin
			r_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[mem_addr] <= r_q;
		end
		if (cmd.rd) begin
			rd_q <= mem[mem_addr];
		end
	end

	assign q_zero     = (q_q == '0);
	assign digit_char = to_ascii(rd_q);

endmodule

FILE: rtl/core/ritoa_ctrl.sv
// ----------------------------------------------------------------------------
// ritoa_ctrl
// Controller: sequences division groups, digit stores and digit emission.
// ----------------------------------------------------------------------------
module ritoa_ctrl import ritoa_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          q_zero,
	output logic                          busy,
	output ritoa_cmd_t                    cmd,
	output logic [$clog2(MAX_DIGITS)-1:0] mem_addr,
	output logic                          strobe,
	output logic                          last_digit
);

	localparam int NSTEP = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
	localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
	localparam int AW    = $clog2(MAX_DIGITS);
	localparam int CW    = $clog2(MAX_DIGITS + 1);

	typedef enum logic [1:0] {
		IDLE,
		DIV,
		STORE,
		EMIT
	} state_t;

	state_t         state_q;
	logic [SW-1:0]  step_q;
	logic [CW-1:0]  cnt_q;
	logic           strobe_q;
	logic           last_q;

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == IDLE) && start;
		cmd.step  = (state_q == DIV);
		cmd.store = (state_q == STORE);
		cmd.rd    = (state_q == EMIT);
		if (state_q == EMIT) begin
			mem_addr = AW'(cnt_q - CW'(1));
		end else begin
			mem_addr = AW'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			step_q   <= '0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= DIV;
						step_q  <= '0;
						cnt_q   <= '0;
					end
				end
				DIV: begin
					if (step_q == SW'(NSTEP - 1)) begin
						step_q  <= '0;
						state_q <= STORE;
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				STORE: begin
					cnt_q <= cnt_q + CW'(1);
					// stop on a zero quotient or a full digit memory
					if (q_zero || (cnt_q == CW'(MAX_DIGITS - 1))) begin
						state_q <= EMIT;
					end else begin
						state_q <= DIV;
					end
				end
				EMIT: begin
					strobe_q <= 1'b1;
					last_q   <= (cnt_q == CW'(1));
					cnt_q    <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != IDLE);
	assign strobe     = strobe_q;
	assign last_digit = last_q;

endmodule

FILE: rtl/core/radix_integer_to_ascii.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii
// Converts an unsigned value to ASCII digits in a programmable base 2..16,
// most significant digit first, flagging the final digit.
// ----------------------------------------------------------------------------
//  channel   signals                               direction
//  request   start, busy, value                    in (start), out (busy)
//  result    strobe, digit_char, last_digit        out, one cycle per digit
//  config    psel, penable, pwrite, paddr, pwdata  in; prdata, pready out
//
//  Each digit is divided out in the DIV state, then written to the digit
//  memory in STORE; the shared long-division unit resolves 8 quotient bits
//  per cycle on a quotient of NSTEP*8 bits, NSTEP = ceil(VALUE_BITS/8).
//  Emission takes one cycle per digit from the digit memory read port, and
//  busy stays high through the division and emission of an item; the last
//  digit is strobed in the first cycle with busy low.
//  Reset is asynchronous, active low, and needs no clearing pass.
//  Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii import ritoa_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  strobe,
	output logic [CHAR_BITS-1:0]  digit_char,
	output logic                  last_digit,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [RADIX_BITS-1:0]         radix_q;
	ritoa_cmd_t                    cmd;
	logic [$clog2(MAX_DIGITS)-1:0] mem_addr;
	logic                          q_zero;
	logic                          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_wr && (paddr[2] == REG_RADIX)) begin
			radix_q <= pwdata[RADIX_BITS-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_RADIX) begin
			prdata = APB_DATA_W'(radix_q);
		end else begin
			prdata = '0;
		end
	end

	ritoa_ctrl #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.q_zero     (q_zero),
		.busy       (busy),
		.cmd        (cmd),
		.mem_addr   (mem_addr),
		.strobe     (strobe),
		.last_digit (last_digit)
	);

	ritoa_dp #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.mem_addr   (mem_addr),
		.value      (value),
		.radix      (radix_q),
		.q_zero     (q_zero),
		.digit_char (digit_char)
	);

endmodule

FILE: tb/sv/radix_integer_to_ascii_test.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_test
// Self-checking bench for the radix integer to ASCII converter: drives values
// through the start/busy port under several bases set over APB, predicts the
// digit stream of each request and compares every strobed digit in order.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_test import ritoa_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int MAX_REPORTS = 10;
	localparam int PHASE_ITEMS = 40;
	localparam int MAX_GAP     = 80;

	localparam logic [APB_ADDR_W-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_RADIX, 2'b00};

	typedef struct packed {
		logic [CHAR_BITS-1:0] ch;
		logic                 last;
	} digit_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [VALUE_BITS_DEF-1:0] value;
	logic                      strobe;
	logic [CHAR_BITS-1:0]      digit_char;
	logic                      last_digit;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_W-1:0]     paddr;
	logic [APB_DATA_W-1:0]     pwdata;
	logic [APB_DATA_W-1:0]     prdata;
	logic                      pready;

	digit_t          pending_digits[$];
	logic [RADIX_BITS-1:0] radix_now;
	int              errors;
	int              cycles;
	bit              gaps_on;

	radix_integer_to_ascii uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last_digit (last_digit),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk     = 1'b0;
		arst_n  = 1'b0;
		start   = 1'b0;
		value   = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
	end

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("radix_integer_to_ascii_test: done, errors");
			$finish;
		end
	end

	function automatic void note_error(string what, logic [31:0] want, logic [31:0] got);
		if (errors < MAX_REPORTS) begin
			$display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
		end
		errors++;
	endfunction

	// Work out the digits of one request, most significant first.
	function automatic void queue_digits_of(input logic [VALUE_BITS_DEF-1:0] v);
		logic [VALUE_BITS_DEF-1:0] q;
		logic [DIGIT_BITS-1:0]     rem[$];
		int unsigned               b;
		digit_t                    d;
		if (radix_now < BASE_MIN) begin
			b = BASE_MIN;
		end else if (radix_now > BASE_MAX) begin
			b = BASE_MAX;
		end else begin
			b = radix_now;
		end
		q = v;
		do begin
			rem.push_back(DIGIT_BITS'(q % b));
			q = q / b;
		end while (q != 0 && rem.size() < MAX_DIGITS_DEF);
		for (int k = rem.size() - 1; k >= 0; k--) begin
			if (rem[k] < DEC_LIMIT) begin
				d.ch = ASC_ZERO + CHAR_BITS'(rem[k]);
			end else begin
				d.ch = ASC_A + CHAR_BITS'(rem[k] - DEC_LIMIT);
			end
			d.last = (k == 0);
			pending_digits.push_back(d);
		end
	endfunction

	always @(posedge clk) begin
		digit_t want;
		if (arst_n && strobe) begin
			if (pending_digits.size() == 0) begin
				note_error("unexpected digit_char", '0, digit_char);
			end else begin
				want = pending_digits.pop_front();
				if (digit_char !== want.ch) begin
					note_error("digit_char", want.ch, digit_char);
				end
				if (last_digit !== want.last) begin
					note_error("last_digit", want.last, last_digit);
				end
			end
		end
	end

	task automatic send_value(input logic [VALUE_BITS_DEF-1:0] v);
		int gap;
		gap = 0;
		if (gaps_on && $urandom_range(99) < 26) begin
			gap = $urandom_range(MAX_GAP, 1);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		queue_digits_of(v);
		start <= 1'b1;
		value <= v;
		// hold until the request is taken; leave start high for a back-to-back one
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait for every expected digit plus a short tail.
	task automatic drain;
		start <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		// idle the bus before the next access
		@(posedge clk);
	endtask

	task automatic check_radix_readback;
		logic [APB_DATA_W-1:0] rd;
		apb_access(1'b0, RADIX_ADDR, $urandom, rd);
		if (rd !== APB_DATA_W'(radix_now)) begin
			note_error("radix readback", radix_now, rd);
		end
	endtask

	task automatic set_radix(input logic [RADIX_BITS-1:0] r);
		logic [APB_DATA_W-1:0] wd;
		logic [APB_DATA_W-1:0] rd;
		drain();
		// junk in the upper bits must be dropped
		wd = $urandom;
		wd[RADIX_BITS-1:0] = r;
		apb_access(1'b1, RADIX_ADDR, wd, rd);
		radix_now = r;
	endtask

	function automatic logic [VALUE_BITS_DEF-1:0] random_value;
		logic [VALUE_BITS_DEF-1:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = $urandom >> $urandom_range(VALUE_BITS_DEF - 1);
			2: v = $urandom_range(40);
			default: v = {VALUE_BITS_DEF{1'b1}} >> $urandom_range(VALUE_BITS_DEF - 1);
		endcase
		return v;
	endfunction

	task automatic test_register_access;
		logic [APB_DATA_W-1:0] rd;
		check_radix_readback();
		// a write to the unused index must not touch the base
		apb_access(1'b1, SPARE_ADDR, 32'd3, rd);
		check_radix_readback();
		send_value(32'd1234567890);
		set_radix(5'd16);
		check_radix_readback();
		set_radix(5'd10);
		check_radix_readback();
	endtask

	task automatic test_directed;
		set_radix(5'd10);
		send_value('0);
		send_value(32'd1);
		send_value(32'd9);
		send_value(32'd10);
		send_value({VALUE_BITS_DEF{1'b1}});
		set_radix(5'd2);
		send_value('0);
		send_value(32'd1);
		send_value(32'h8000_0000);
		send_value({VALUE_BITS_DEF{1'b1}});
		set_radix(5'd16);
		send_value('0);
		send_value(32'd15);
		send_value(32'd16);
		send_value(32'hABCD_EF01);
		send_value({VALUE_BITS_DEF{1'b1}});
		// bases outside 2..16 saturate
		set_radix(5'd0);
		send_value(32'd5);
		set_radix(5'd1);
		send_value(32'd6);
		set_radix(5'd17);
		send_value(32'd255);
		set_radix(5'd31);
		send_value({VALUE_BITS_DEF{1'b1}});
		set_radix(5'd3);
		send_value({VALUE_BITS_DEF{1'b1}});
		set_radix(5'd7);
		send_value(32'h5555_AAAA);
	endtask

	task automatic test_random_values;
		logic [RADIX_BITS-1:0] bases[10];
		bases = '{5'd16, 5'd2, 5'd10, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
		for (int p = 0; p < 10; p++) begin
			if (p >= 5) begin
				bases[p] = $urandom_range((1 << RADIX_BITS) - 1);
			end
			set_radix(bases[p]);
			gaps_on = (p != 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_value(random_value());
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		errors    = 0;
		cycles    = 0;
		gaps_on   = 1'b1;
		radix_now = RADIX_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_directed();
		test_random_values();

		drain();
		repeat (20) @(posedge clk);
		if (pending_digits.size() != 0) begin
			note_error("digits never produced", pending_digits.size(), 0);
		end
		if (errors == 0) begin
			$display("radix_integer_to_ascii_test: done, clean");
		end else begin
			$display("radix_integer_to_ascii_test: done, errors");
		end
		$finish;
	end

endmodule
